### rtl/byte_stack_bytecode_executor_macros.svh
// Assertion macros for the executor's top-level RTL file.
`ifndef BYTE_STACK_BYTECODE_EXECUTOR_MACROS_SVH
`define BYTE_STACK_BYTECODE_EXECUTOR_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define BSBE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define BSBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bsbe_pkg.sv
// Shared constants, codes and types of the byte-stack bytecode executor.
package bsbe_pkg;

  localparam int STACK_BYTES = 65536;
  localparam int MAX_PRINT   = 64;
  localparam int ADDR_W      = $clog2(STACK_BYTES);
  localparam int FILL_W      = ADDR_W + 1;
  localparam int WORD_W      = 32;
  localparam int WORD_BYTES  = WORD_W / 8;
  localparam int BE_W        = 2 * WORD_BYTES;
  localparam int ROW_W       = ADDR_W - 2;
  localparam int BANK_AW     = ROW_W - 1;
  localparam int BANK_ROWS   = STACK_BYTES / (2 * WORD_BYTES);
  localparam int LEN_W       = 7;
  localparam int DIV_CNT_W   = $clog2(WORD_W);

  typedef enum logic [2:0] {
    OP_PUSH_IMM  = 3'd0,
    OP_PUSH_COPY = 3'd1,
    OP_ADD       = 3'd2,
    OP_SUB       = 3'd3,
    OP_MUL       = 3'd4,
    OP_DIV       = 3'd5,
    OP_PUSH_BYTE = 3'd6,
    OP_EMIT      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_BEYOND   = 2'd2,
    ST_DIVZERO  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_B,
    S_OP,
    S_DIV,
    S_COPY,
    S_WRITE,
    S_RESULT,
    S_PRINT
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_offset;
    logic              wr_en;
    logic              wr_single;
    logic [ADDR_W-1:0] wr_offset;
    logic [WORD_W-1:0] wr_data;
  } mem_req_t;

endpackage

### rtl/bsbe_stack_mem.sv
// Byte-addressed stack memory: two word banks giving unaligned word access.
module bsbe_stack_mem (
  input  logic               clk,
  input  bsbe_pkg::mem_req_t req,
  output logic [31:0]        rd_word
);
  import bsbe_pkg::*;

  // Even rows in one bank, odd rows in the other: any 4-byte window spans
  // at most one row of each.
  logic [WORD_W-1:0] even_bank [BANK_ROWS];
  logic [WORD_W-1:0] odd_bank  [BANK_ROWS];

  logic [ROW_W-1:0]      wr_row;
  logic [1:0]            wr_lane;
  logic [2*WORD_W-1:0]   wr_win;
  logic [BE_W-1:0]       wr_be;
  logic [BANK_AW-1:0]    even_wa, odd_wa;
  logic [WORD_BYTES-1:0] even_we, odd_we;
  logic [WORD_W-1:0]     even_wd, odd_wd;

  logic [ROW_W-1:0]      rd_row;
  logic [BANK_AW-1:0]    even_ra, odd_ra;
  logic [WORD_W-1:0]     even_q, odd_q;
  logic                  rd_odd_lo;
  logic [1:0]            rd_lane;
  logic [2*WORD_W-1:0]   rd_win, rd_shifted;

  assign wr_row  = req.wr_offset[ADDR_W-1:2];
  assign wr_lane = req.wr_offset[1:0];
  assign wr_win  = {{WORD_W{1'b0}}, req.wr_data} << {wr_lane, 3'b000};
  assign wr_be   = BE_W'(req.wr_single ? 4'h1 : 4'hF) << wr_lane;
  assign odd_wa  = wr_row[ROW_W-1:1];
  assign even_wa = wr_row[0] ? odd_wa + BANK_AW'(1) : odd_wa;
  assign even_we = wr_row[0] ? wr_be[BE_W-1:WORD_BYTES] : wr_be[WORD_BYTES-1:0];
  assign odd_we  = wr_row[0] ? wr_be[WORD_BYTES-1:0] : wr_be[BE_W-1:WORD_BYTES];
  assign even_wd = wr_row[0] ? wr_win[2*WORD_W-1:WORD_W] : wr_win[WORD_W-1:0];
  assign odd_wd  = wr_row[0] ? wr_win[WORD_W-1:0] : wr_win[2*WORD_W-1:WORD_W];

  assign rd_row  = req.rd_offset[ADDR_W-1:2];
  assign odd_ra  = rd_row[ROW_W-1:1];
  assign even_ra = rd_row[0] ? odd_ra + BANK_AW'(1) : odd_ra;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      for (int k = 0; k < WORD_BYTES; k++) begin
        if (even_we[k]) even_bank[even_wa][8*k +: 8] <= even_wd[8*k +: 8];
        if (odd_we[k])  odd_bank[odd_wa][8*k +: 8]   <= odd_wd[8*k +: 8];
      end
    end
  end

  // Hold the read data until the next read.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      even_q    <= even_bank[even_ra];
      odd_q     <= odd_bank[odd_ra];
      rd_odd_lo <= rd_row[0];
      rd_lane   <= req.rd_offset[1:0];
    end
  end

  assign rd_win     = rd_odd_lo ? {even_q, odd_q} : {odd_q, even_q};
  assign rd_shifted = rd_win >> {rd_lane, 3'b000};
  assign rd_word    = rd_shifted[WORD_W-1:0];

endmodule

### rtl/bsbe_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating to zero.
module bsbe_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import bsbe_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [WORD_W-1:0]    rem, quo, mag_b;
  logic                 neg;
  logic [WORD_W:0]      trial;
  logic [WORD_W-1:0]    rem_next, quo_next;

  always_comb begin
    trial = {rem, quo[WORD_W-1]} - {1'b0, mag_b};
    if (!trial[WORD_W]) begin
      rem_next = trial[WORD_W-1:0];
      quo_next = {quo[WORD_W-2:0], 1'b1};
    end else begin
      rem_next = {rem[WORD_W-2:0], quo[WORD_W-1]};
      quo_next = {quo[WORD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + DIV_CNT_W'(1);
        if (count == DIV_CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= dividend[WORD_W-1] ? -dividend : dividend;
      mag_b <= divisor[WORD_W-1] ? -divisor : divisor;
      neg   <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = neg ? -quo : quo;

endmodule

### rtl/byte_stack_bytecode_executor.sv
// Top level of the byte-stack bytecode executor: sequencer and result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  request  | req_valid, req_stall | req_type, immediate, offset_a, offset_b,
//           |                      | data_byte, last_byte, print_length
//  response | rsp_valid, rsp_stall | status, out_valid, out_byte, out_last,
//           |                      | stack_used
//
// One instruction is in flight at a time; a new request is taken while the
// previous result still waits in the response register. An instruction steps
// through decode, any stack bank reads (registered), its operation and any
// stack write before its result or print step; the divider resolves one
// quotient bit a cycle, and a print returns one byte per bank read. A failed
// bounds check, a zero-length print or a zero divisor goes straight to the
// result step. Reset is synchronous and needs no clearing pass; the stack
// contents stay undefined until pushed. A stalled response register holds
// the sequencer in its result or print step.
module byte_stack_bytecode_executor (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         req_type,
  input  logic signed [31:0] immediate,
  input  logic [15:0]        offset_a,
  input  logic [15:0]        offset_b,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  logic [6:0]         print_length,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [1:0]         status,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output logic [16:0]        stack_used
);
  import bsbe_pkg::*;

  // last_byte only marks string ends for the producer; it changes no state.

  state_t            state, state_next;
  op_t               op;
  logic [WORD_W-1:0] imm;
  logic [ADDR_W-1:0] off_a, off_b;
  logic [7:0]        dbyte;
  logic [LEN_W-1:0]  plen;
  logic [LEN_W-1:0]  idx;
  logic [WORD_W-1:0] opa;
  logic [WORD_W-1:0] result;
  status_t           st;
  logic [FILL_W-1:0] fill;

  mem_req_t          mem_req;
  logic [WORD_W-1:0] rd_word;
  logic              div_start, div_done;
  logic [WORD_W-1:0] div_q;

  logic              out_free, rsp_load, req_take;
  logic              rd_a_ok, rd_b_ok, print_ok, room, print_end;
  logic [ADDR_W-1:0] print_addr;

  bsbe_stack_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_word (rd_word)
  );

  bsbe_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (opa),
    .divisor  (rd_word),
    .done     (div_done),
    .quotient (div_q)
  );

  // Bounds checks against the fill pointer.
  assign rd_a_ok  = ({1'b0, off_a} + FILL_W'(WORD_BYTES)) <= fill;
  assign rd_b_ok  = ({1'b0, off_b} + FILL_W'(WORD_BYTES)) <= fill;
  assign print_ok = ({1'b0, off_a} + FILL_W'(plen)) <= fill;
  assign room     = (op == OP_PUSH_BYTE) ? (fill < FILL_W'(STACK_BYTES))
                  : (({1'b0, fill} + (FILL_W+1)'(WORD_BYTES)) <= (FILL_W+1)'(STACK_BYTES));

  assign out_free   = !rsp_valid || !rsp_stall;
  assign req_take   = req_valid && !req_stall;
  assign print_end  = (idx + LEN_W'(1)) == plen;
  assign print_addr = off_a + ADDR_W'(idx) + ADDR_W'(1);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_valid) state_next = S_DECODE;
      S_DECODE: begin
        unique case (op)
          OP_PUSH_IMM, OP_PUSH_BYTE: state_next = S_WRITE;
          OP_PUSH_COPY: state_next = rd_a_ok ? S_COPY : S_RESULT;
          OP_ADD, OP_SUB, OP_MUL, OP_DIV:
            state_next = (rd_a_ok && rd_b_ok) ? S_RD_B : S_RESULT;
          OP_EMIT: state_next = (print_ok && plen != '0) ? S_PRINT : S_RESULT;
          default: state_next = S_RESULT;
        endcase
      end
      S_RD_B: state_next = S_OP;
      S_OP: begin
        if (op == OP_DIV) state_next = (rd_word == '0) ? S_RESULT : S_DIV;
        else              state_next = S_WRITE;
      end
      S_DIV:    if (div_done) state_next = S_WRITE;
      S_COPY:   state_next = S_WRITE;
      S_WRITE:  state_next = S_RESULT;
      S_RESULT: if (out_free) state_next = S_IDLE;
      S_PRINT:  if (out_free && print_end) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control outputs and memory requests.
  always_comb begin
    req_stall         = 1'b1;
    rsp_load          = 1'b0;
    div_start         = 1'b0;
    mem_req.rd_en     = 1'b0;
    mem_req.rd_offset = off_a;
    mem_req.wr_en     = 1'b0;
    mem_req.wr_single = (op == OP_PUSH_BYTE);
    mem_req.wr_offset = fill[ADDR_W-1:0];
    mem_req.wr_data   = result;
    unique case (state)
      S_IDLE: req_stall = 1'b0;
      S_DECODE: begin
        // Issue the first read early; a failing check simply ignores it.
        mem_req.rd_en = (op != OP_PUSH_IMM) && (op != OP_PUSH_BYTE);
      end
      S_RD_B: begin
        mem_req.rd_en     = 1'b1;
        mem_req.rd_offset = off_b;
      end
      S_OP:     div_start = (op == OP_DIV) && (rd_word != '0);
      S_WRITE:  mem_req.wr_en = room;
      S_RESULT: rsp_load = out_free;
      S_PRINT: begin
        rsp_load          = out_free;
        mem_req.rd_en     = out_free && !print_end;
        mem_req.rd_offset = print_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      if (state == S_WRITE && room) begin
        fill <= fill + ((op == OP_PUSH_BYTE) ? FILL_W'(1) : FILL_W'(WORD_BYTES));
      end
    end
  end

  // Instruction registers and working values.
  always_ff @(posedge clk) begin
    if (req_take) begin
      op    <= op_t'(req_type);
      imm   <= $unsigned(immediate);
      off_a <= offset_a;
      off_b <= offset_b;
      dbyte <= data_byte;
      plen  <= (print_length > LEN_W'(MAX_PRINT)) ? LEN_W'(MAX_PRINT) : print_length;
      idx   <= '0;
      st    <= ST_OK;
    end
    unique case (state)
      S_DECODE: begin
        result <= (op == OP_PUSH_BYTE) ? {{(WORD_W-8){1'b0}}, dbyte} : imm;
        priority if (op == OP_PUSH_COPY && !rd_a_ok) st <= ST_BEYOND;
        else if ((op == OP_ADD || op == OP_SUB || op == OP_MUL || op == OP_DIV)
                 && !(rd_a_ok && rd_b_ok)) st <= ST_BEYOND;
        else if (op == OP_EMIT && !print_ok) st <= ST_BEYOND;
        else st <= ST_OK;
      end
      S_RD_B: opa <= rd_word;
      S_OP: begin
        unique case (op)
          OP_ADD:  result <= opa + rd_word;
          OP_SUB:  result <= opa - rd_word;
          OP_MUL:  result <= opa * rd_word;
          default: if (rd_word == '0) st <= ST_DIVZERO;
        endcase
      end
      S_DIV:   if (div_done) result <= div_q;
      S_COPY:  result <= rd_word;
      S_WRITE: if (!room) st <= ST_OVERFLOW;
      S_PRINT: if (out_free && !print_end) idx <= idx + LEN_W'(1);
      default: ;
    endcase
  end

  // Response register: take a new result once the old one leaves or the register is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      stack_used <= fill;
      if (state == S_PRINT) begin
        status    <= ST_OK;
        out_valid <= 1'b1;
        out_byte  <= rd_word[7:0];
        out_last  <= print_end;
      end else begin
        status    <= st;
        out_valid <= 1'b0;
        out_byte  <= '0;
        out_last  <= 1'b1;
      end
    end
  end

  `include "byte_stack_bytecode_executor_macros.svh"

  `BSBE_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill <= FILL_W'(STACK_BYTES), "fill pointer past stack end")
  `BSBE_ASSERT_NEXT(a_fill_only_on_write, clk, rst, state != S_WRITE, $stable(fill), "fill moved outside a push")
  `BSBE_ASSERT_NOW(a_div_nonzero, clk, rst, div_start, rd_word != '0, "divider started on zero divisor")
  `BSBE_ASSERT_NOW(a_print_ok, clk, rst, rsp_valid && out_valid, status == ST_OK, "printed byte carries an error")

endmodule

### tb/sv/byte_stack_bytecode_executor_tb.sv
// Self-checking testbench for the byte-stack bytecode executor: directed and random runs.
`timescale 1ns / 1ps

module byte_stack_bytecode_executor_tb;
  import bsbe_pkg::*;

  // One decoded instruction as it is put on the request channel.
  typedef struct {
    op_t         op;
    logic [31:0] imm;
    logic [15:0] oa;
    logic [15:0] ob;
    logic [7:0]  db;
    logic        lb;
    logic [6:0]  plen;
  } instr_t;

  // One response transaction as the executor should present it.
  typedef struct {
    status_t     st;
    logic        shown;
    logic [7:0]  data;
    logic        last;
    logic [16:0] used;
  } result_t;

  // Stimulus ports start known; the driver takes over after reset.
  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               req_valid    = 1'b0;
  logic               req_stall;
  logic [2:0]         req_type     = '0;
  logic signed [31:0] immediate    = '0;
  logic [15:0]        offset_a     = '0;
  logic [15:0]        offset_b     = '0;
  logic [7:0]         data_byte    = '0;
  logic               last_byte    = 1'b0;
  logic [6:0]         print_length = '0;
  logic               rsp_valid;
  logic               rsp_stall    = 1'b0;
  logic [1:0]         status;
  logic               out_valid;
  logic [7:0]         out_byte;
  logic               out_last;
  logic [16:0]        stack_used;

  // Instructions waiting to be driven, and responses the executor still owes.
  instr_t     instr_queue[$];
  result_t    due_results[$];

  // Our own image of the stack and its fill pointer. Bytes at or above the
  // fill pointer are never read, so the image needs no clearing.
  logic [7:0] stack_image [STACK_BYTES];
  int         stack_fill = 0;

  int unsigned cycle_count = 0;
  int          errors      = 0;
  int          n_instr     = 0;
  int          n_results   = 0;
  int          n_printed   = 0;
  int          status_seen [4] = '{default: 0};
  instr_t      drive_item;
  result_t     want;

  // A window with no idling on either side, so back-to-back transactions
  // hit every step of the sequencer as well.
  wire quiet = (cycle_count >= 1000) && (cycle_count < 2500);

  byte_stack_bytecode_executor u_top (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .immediate    (immediate),
    .offset_a     (offset_a),
    .offset_b     (offset_b),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .print_length (print_length),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .stack_used   (stack_used)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Little-endian word at any byte offset of the stack image.
  function automatic logic [31:0] word_at(int o);
    return {stack_image[o + 3], stack_image[o + 2], stack_image[o + 1], stack_image[o]};
  endfunction

  // Execute one instruction against the stack image and queue the responses
  // it must produce. A failing instruction leaves the image untouched.
  task automatic run_instruction(instr_t ins);
    logic [31:0] a, b, r, ma, mb, q;
    status_t     st;
    bit          push;
    int          n, i;
    st   = ST_OK;
    push = 1'b0;
    r    = '0;
    case (ins.op)
      OP_PUSH_IMM: begin
        r    = ins.imm;
        push = 1'b1;
      end
      OP_PUSH_COPY: begin
        if (int'(ins.oa) + 4 > stack_fill) st = ST_BEYOND;
        else begin
          r    = word_at(ins.oa);
          push = 1'b1;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        // Both operand reads are checked before the divisor and the room.
        if (int'(ins.oa) + 4 > stack_fill || int'(ins.ob) + 4 > stack_fill) begin
          st = ST_BEYOND;
        end else begin
          a    = word_at(ins.oa);
          b    = word_at(ins.ob);
          push = 1'b1;
          case (ins.op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            default: begin
              if (b == '0) begin
                st   = ST_DIVZERO;
                push = 1'b0;
              end else begin
                // Divide magnitudes and restore the sign: truncates toward
                // zero, and the most negative word over minus one wraps.
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                q  = ma / mb;
                r  = (a[31] ^ b[31]) ? -q : q;
              end
            end
          endcase
        end
      end
      OP_PUSH_BYTE: begin
        if (stack_fill + 1 > STACK_BYTES) st = ST_OVERFLOW;
        else begin
          stack_image[stack_fill] = ins.db;
          stack_fill++;
        end
      end
      default: begin
        // Print: clip the length first, then check the range against the fill.
        n = (ins.plen > MAX_PRINT) ? MAX_PRINT : ins.plen;
        if (int'(ins.oa) + n > stack_fill) st = ST_BEYOND;
        else if (n > 0) begin
          for (i = 0; i < n; i++)
            due_results.push_back('{ST_OK, 1'b1, stack_image[int'(ins.oa) + i],
                                    (i == n - 1), stack_fill[16:0]});
          return;
        end
      end
    endcase
    if (push) begin
      if (stack_fill + 4 > STACK_BYTES) st = ST_OVERFLOW;
      else begin
        for (i = 0; i < 4; i++) stack_image[stack_fill + i] = r[8 * i +: 8];
        stack_fill += 4;
      end
    end
    due_results.push_back('{st, 1'b0, 8'h00, 1'b1, stack_fill[16:0]});
  endtask

  // Queue one instruction. Fields the operation does not use get random
  // values, so every bit of every field toggles along the way.
  task automatic queue_instr(op_t op, logic [31:0] imm = '0, int oa = 0, int ob = 0,
                             logic [7:0] db = '0, int plen = 0);
    instr_t it;
    bit     arith;
    arith = (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) || (op == OP_DIV);
    it = '{op, imm, 16'(oa), 16'(ob), db, 1'($urandom), 7'(plen)};
    if (op != OP_PUSH_IMM) it.imm = $urandom;
    if (!arith && op != OP_PUSH_COPY && op != OP_EMIT) it.oa = 16'($urandom);
    if (!arith) it.ob = 16'($urandom);
    if (op != OP_PUSH_BYTE) it.db = 8'($urandom);
    if (op != OP_EMIT) it.plen = 7'($urandom);
    instr_queue.push_back(it);
  endtask

  // Words worth pushing: the signed extremes, zero (for divide by zero) and
  // small values (for non-trivial quotients) turn up often.
  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom_range(1, 16);
      default: return $urandom;
    endcase
  endfunction

  // Mostly a readable word, weighted toward the freshly pushed ones; the rest
  // straddles the fill pointer or lands anywhere.
  function automatic int word_offset(int fill);
    int r;
    r = $urandom_range(0, 99);
    if (fill >= 4 && r < 45) return $urandom_range(0, fill - 4);
    if (fill >= 4 && r < 85) return $urandom_range(fill > 40 ? fill - 40 : 0, fill - 4);
    if (r < 93) return (fill < 3 ? 0 : fill - 3) + $urandom_range(0, 3);
    return $urandom_range(0, 65535);
  endfunction

  task automatic queue_random_instr();
    int pick, fill, n, clip, oa;
    fill = stack_fill;
    pick = $urandom_range(0, 99);
    if (pick < 18) queue_instr(OP_PUSH_IMM, random_word());
    else if (pick < 28) queue_instr(OP_PUSH_COPY, 0, word_offset(fill));
    else if (pick < 63) begin
      queue_instr(op_t'($urandom_range(int'(OP_ADD), int'(OP_DIV))), 0,
                  word_offset(fill), word_offset(fill));
    end else if (pick < 78) queue_instr(OP_PUSH_BYTE, 0, 0, 0, 8'($urandom));
    else begin
      // Mostly short prints, some long ones, some past the clip length.
      case ($urandom_range(0, 6))
        5:       n = $urandom_range(17, 64);
        6:       n = $urandom_range(65, 127);
        default: n = $urandom_range(0, 16);
      endcase
      clip = (n > MAX_PRINT) ? MAX_PRINT : n;
      if (clip <= fill && $urandom_range(0, 99) < 85) oa = $urandom_range(0, fill - clip);
      else if ($urandom_range(0, 1) == 0) oa = fill - clip + $urandom_range(1, 4);
      else oa = $urandom_range(0, 65535);
      if (oa < 0) oa = $urandom_range(0, 65535);
      queue_instr(OP_EMIT, 0, oa, 0, 0, n);
    end
  endtask

  // Block until every queued instruction has been taken by the executor.
  task automatic wait_drained();
    do @(negedge clk); while (instr_queue.size() != 0 || req_valid);
  endtask

  // Driver: present the next instruction once the current transaction has
  // gone, or idle now and then outside the quiet window.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (instr_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= 16)) begin
        drive_item   = instr_queue.pop_front();
        req_valid    <= 1'b1;
        req_type     <= drive_item.op;
        immediate    <= drive_item.imm;
        offset_a     <= drive_item.oa;
        offset_b     <= drive_item.ob;
        data_byte    <= drive_item.db;
        last_byte    <= drive_item.lb;
        print_length <= drive_item.plen;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on every accepted request, check every accepted
  // response against the oldest outstanding one, and stall at random.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 16);
      if (req_valid && !req_stall) begin
        run_instruction('{op_t'(req_type), immediate, offset_a, offset_b, data_byte,
                          last_byte, print_length});
        n_instr++;
      end
      if (rsp_valid && !rsp_stall) begin
        if (due_results.size() == 0) begin
          errors++;
          $error("response (status %0d, byte %0h) with nothing outstanding", status, out_byte);
        end else begin
          want = due_results.pop_front();
          n_results++;
          status_seen[want.st]++;
          if (want.shown) n_printed++;
          if (status !== want.st) begin
            errors++;
            $error("status: expected %0d, got %0d", want.st, status);
          end
          if (out_valid !== want.shown) begin
            errors++;
            $error("out_valid: expected %0b, got %0b", want.shown, out_valid);
          end
          if (out_byte !== want.data) begin
            errors++;
            $error("out_byte: expected %02h, got %02h", want.data, out_byte);
          end
          if (out_last !== want.last) begin
            errors++;
            $error("out_last: expected %0b, got %0b", want.last, out_last);
          end
          if (stack_used !== want.used) begin
            errors++;
            $error("stack_used: expected %0d, got %0d", want.used, stack_used);
          end
        end
      end
    end
  end

  // Stimulus: reset, a directed opening, then random batches.
  initial begin
    int k;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty stack: a zero-length print passes, every read is beyond the fill.
    queue_instr(OP_EMIT, 0, 0, 0, 0, 0);
    queue_instr(OP_EMIT, 0, 0, 0, 0, 1);
    queue_instr(OP_PUSH_COPY, 0, 0);
    queue_instr(OP_ADD, 0, 0, 0);
    // Signed extremes and small operands at 0, 4, 8, 12, 16, 20.
    queue_instr(OP_PUSH_IMM, 32'h7FFF_FFFF);
    queue_instr(OP_PUSH_IMM, 32'h8000_0000);
    queue_instr(OP_PUSH_IMM, 32'hFFFF_FFFF);
    queue_instr(OP_PUSH_IMM, 32'h0000_0000);
    queue_instr(OP_PUSH_IMM, 32'hFFFF_FFF9);
    queue_instr(OP_PUSH_IMM, 32'h0000_0002);
    // Two string bytes leave the fill unaligned.
    queue_instr(OP_PUSH_BYTE, 0, 0, 0, 8'hFF);
    queue_instr(OP_PUSH_BYTE, 0, 0, 0, 8'h00);
    // Quotient overflow, divide by zero, truncation toward zero both ways.
    queue_instr(OP_DIV, 0, 4, 8);
    queue_instr(OP_DIV, 0, 0, 12);
    queue_instr(OP_DIV, 0, 16, 20);
    queue_instr(OP_DIV, 0, 20, 16);
    // Wrapping sum, difference and product.
    queue_instr(OP_ADD, 0, 0, 0);
    queue_instr(OP_SUB, 0, 4, 0);
    queue_instr(OP_MUL, 0, 0, 8);
    // Unaligned copy, then an operand ending exactly at the fill and one past it.
    queue_instr(OP_PUSH_COPY, 0, 23);
    queue_instr(OP_ADD, 0, 47, 50);
    queue_instr(OP_SUB, 0, 55, 0);
    // Print up to the fill, a clipped print past it, and the top offsets.
    queue_instr(OP_EMIT, 0, 20, 0, 0, 38);
    queue_instr(OP_EMIT, 0, 0, 0, 0, 100);
    queue_instr(OP_PUSH_COPY, 0, 65535);
    queue_instr(OP_MUL, 0, 0, 65535);

    // Random batches; drain between them so offsets follow the real fill.
    for (k = 0; k < 24; k++) begin
      wait_drained();
      repeat (10) queue_random_instr();
    end

    // Hold until every response is in, then give a stray one time to show.
    wait_drained();
    while (due_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);

    $display("Ran %0d instructions up to a fill of %0d of %0d bytes;",
             n_instr, stack_fill, STACK_BYTES);
    $display("%0d responses checked (%0d printed bytes): ok %0d, overflow %0d, beyond %0d, div0 %0d.",
             n_results, n_printed, status_seen[ST_OK], status_seen[ST_OVERFLOW],
             status_seen[ST_BEYOND], status_seen[ST_DIVZERO]);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### byte_stack_bytecode_executor.f
+incdir+rtl
rtl/bsbe_pkg.sv
rtl/bsbe_stack_mem.sv
rtl/bsbe_divider.sv
rtl/byte_stack_bytecode_executor.sv
tb/sv/byte_stack_bytecode_executor_tb.sv
